>>> rtl/kmpp_pkg.sv
package kmpp_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int MAX_CENTERS = 16;
    localparam int DIMS        = 4;
    localparam int COORD_BITS  = 16;

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int NPW  = AW + 1;
    localparam int CNW  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int NCW  = CNW + 1;
    localparam int SQW  = 2 * COORD_BITS;
    localparam int LDW  = SQW + $clog2(DIMS) + 1;
    localparam int PSW  = LDW + AW;

    localparam int IN_BITS  = ((DIMS * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_RAW  = CNW + AW + DIMS * COORD_BITS;
    localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8;

    localparam logic [31:0] SEED_RESET = 32'd2463534242;

    localparam logic [1:0] REG_NUM_POINTS  = 2'd0;
    localparam logic [1:0] REG_NUM_CENTERS = 2'd1;
    localparam logic [1:0] REG_NUM_DIMS    = 2'd2;
    localparam logic [1:0] REG_SEED        = 2'd3;

    localparam logic KIND_LOAD = 1'b0;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [SQW-1:0]               t_sq;
    typedef logic [LDW-1:0]               t_ld;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DRAW0, ST_FETCH, ST_FWAIT, ST_EMIT, ST_PASS, ST_DRAIN,
        ST_KEY1, ST_KEY2, ST_S_LO, ST_S_HI, ST_S_MID, ST_S_CMP
    } t_state;

    function automatic logic [31:0] xorshift(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

endpackage

>>> rtl/kmpp_lane.sv
module kmpp_lane (
    input  logic            i_clk,
    input  kmpp_pkg::t_coord i_point,
    input  kmpp_pkg::t_coord i_center,
    input  logic            i_en,
    output kmpp_pkg::t_sq   o_sq
);
    import kmpp_pkg::*;

    logic signed [COORD_BITS:0] diff;
    t_sq                        r_sq;

    assign diff = i_en ? ({i_point[COORD_BITS-1], i_point} - {i_center[COORD_BITS-1], i_center})
                       : '0;

    always_ff @(posedge i_clk) begin
        r_sq <= SQW'(diff * diff);
    end

    assign o_sq = r_sq;
endmodule

>>> rtl/kmpp_merge.sv
module kmpp_merge (
    input  logic                i_clk,
    input  kmpp_pkg::t_sq [kmpp_pkg::DIMS-1:0] i_sq,
    output kmpp_pkg::t_ld       o_sum
);
    import kmpp_pkg::*;

    t_ld sum;
    t_ld r_sum;

    always_comb begin
        sum = '0;
        for (int d = 0; d < DIMS; d++) begin
            sum = sum + LDW'(i_sq[d]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= sum;
    end

    assign o_sum = r_sum;
endmodule

>>> rtl/kmeanspp_center_seeding_top.sv
// k-means++ seeding. Load beats (tuser 0) write one point per cycle at the
// load pointer while idle; a start beat (tuser 1) picks the configured
// number of centers and sends one output beat per center, tlast on the
// final one. While seeding runs, o_s_tready is low. The first center goes
// from the start beat through the draw, the point read (ST_FETCH, ST_FWAIT)
// and the send. Each center after the first costs a distance pass over all
// points, with one coordinate lane per dimension reading the point memory
// one point per cycle. Then come the key draw (ST_KEY1, ST_KEY2) and a
// binary search through the prefix-sum memory, each halving step running
// through ST_S_LO, ST_S_HI, ST_S_MID and ST_S_CMP. Last come the read of
// the chosen point and its send. A send also waits while the previous
// output beat is still held by a low i_m_tready.
module kmeanspp_center_seeding_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // coord_a, coord_b, coord_c, coord_d from bit 0 up
    input  logic [kmpp_pkg::IN_BITS-1:0]   i_s_tdata,
    // kind
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // center_number, point_index, center_a, center_b, center_c, center_d,
    // zero padding, from bit 0 up
    output logic [kmpp_pkg::OUT_BITS-1:0]  o_m_tdata,
    output logic                           o_m_tlast,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [31:0]                    i_cfg_data
);
    import kmpp_pkg::*;

    localparam int PW = DIMS * COORD_BITS;

    logic [PW-1:0]  pt_mem [MAX_POINTS];
    t_ld            ld_mem [MAX_POINTS];
    logic [PSW-1:0] ps_mem [MAX_POINTS];

    t_state r_state, n_state;

    logic [NPW-1:0] r_np;
    logic [NCW-1:0] r_nc;
    logic [2:0]     r_nd;
    logic [31:0]    r_rand, n_rand;
    logic [AW-1:0]  r_lp, n_lp;

    logic [NPW-1:0] r_m, n_m;
    logic [NCW-1:0] r_k, n_k;
    logic [2:0]     r_dims, n_dims;
    logic [CNW-1:0] r_c, n_c;
    logic [AW-1:0]  r_idx, n_idx;
    logic [AW-1:0]  r_j, n_j;
    logic           r_first, n_first;
    logic [PSW-1:0] r_run, n_run;
    logic [PSW-1:0] r_total, n_total;
    logic [63:0]    r_ph, n_ph, r_pl, n_pl;
    logic [PSW-1:0] r_key, n_key;
    logic [AW-1:0]  r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [PSW-1:0] r_vlo, n_vlo;

    t_coord [DIMS-1:0] r_cen, n_cen;

    logic                r_out_v, n_out_v;
    logic [OUT_BITS-1:0] r_out_d, n_out_d;
    logic                r_out_l, n_out_l;

    logic [PW-1:0]  r_pt_q;
    t_ld            r_ld_q;
    logic [PSW-1:0] r_ps_q;
    logic [AW-1:0]  pt_raddr, ps_raddr;

    logic           r_p1_v, r_p2_v, r_p3_v;
    logic [AW-1:0]  r_p1_j, r_p2_j, r_p3_j;
    t_ld            r_ld_d2, r_ld_d3;

    t_sq [DIMS-1:0] lane_sq;
    t_ld            dd;
    t_ld            new_ld;
    logic [PSW-1:0] run_next;
    logic [31:0]    w;

    assign w = xorshift(r_rand);

    // Distance lanes and merge.
    for (genvar d = 0; d < DIMS; d++) begin : g_lane
        kmpp_lane u_lane (
            .i_clk    (i_clk),
            .i_point  (r_pt_q[d*COORD_BITS +: COORD_BITS]),
            .i_center (r_cen[d]),
            .i_en     (d < int'(r_dims)),
            .o_sq     (lane_sq[d])
        );
    end

    kmpp_merge u_merge (
        .i_clk (i_clk),
        .i_sq  (lane_sq),
        .o_sum (dd)
    );

    assign new_ld   = (r_first || dd < r_ld_d3) ? dd : r_ld_d3;
    assign run_next = r_run + PSW'(new_ld);

    // Memories.
    assign pt_raddr = (r_state == ST_FETCH) ? r_idx : r_j;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_s_tvalid && i_s_tuser == KIND_LOAD) begin
            pt_mem[r_lp] <= i_s_tdata[PW-1:0];
        end
        r_pt_q <= pt_mem[pt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_p3_v) begin
            ld_mem[r_p3_j] <= new_ld;
            ps_mem[r_p3_j] <= run_next;
        end
        r_ld_q <= ld_mem[r_j];
        r_ps_q <= ps_mem[ps_raddr];
    end

    // Pass pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
        end else begin
            r_p1_v <= (r_state == ST_PASS);
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
        end
        r_p1_j  <= r_j;
        r_p2_j  <= r_p1_j;
        r_p3_j  <= r_p2_j;
        r_ld_d2 <= r_ld_q;
        r_ld_d3 <= r_ld_d2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_np    <= NPW'(MAX_POINTS);
            r_nc    <= NCW'(4);
            r_nd    <= 3'(DIMS);
            r_rand  <= SEED_RESET;
            r_lp    <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rand  <= (i_cfg_we && i_cfg_idx == REG_SEED) ? i_cfg_data : n_rand;
            r_lp    <= n_lp;
            r_out_v <= n_out_v;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_NUM_POINTS:  r_np <= i_cfg_data[NPW-1:0];
                    REG_NUM_CENTERS: r_nc <= i_cfg_data[NCW-1:0];
                    REG_NUM_DIMS:    r_nd <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
        end
        r_m     <= n_m;
        r_k     <= n_k;
        r_dims  <= n_dims;
        r_c     <= n_c;
        r_idx   <= n_idx;
        r_j     <= n_j;
        r_first <= n_first;
        r_run   <= n_run;
        r_total <= n_total;
        r_ph    <= n_ph;
        r_pl    <= n_pl;
        r_key   <= n_key;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_vlo   <= n_vlo;
        r_cen   <= n_cen;
        r_out_d <= n_out_d;
        r_out_l <= n_out_l;
    end

    always_comb begin
        logic [AW:0]    range_w;
        logic [AW:0]    mid_w;
        logic [63:0]    tot64;
        logic [NPW+31:0] prod0;
        logic [AW+32:0] prod1;
        n_state = r_state;
        n_rand  = r_rand;
        n_lp    = r_lp;
        n_m     = r_m;
        n_k     = r_k;
        n_dims  = r_dims;
        n_c     = r_c;
        n_idx   = r_idx;
        n_j     = r_j;
        n_first = r_first;
        n_run   = r_run;
        n_total = r_total;
        n_ph    = r_ph;
        n_pl    = r_pl;
        n_key   = r_key;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_vlo   = r_vlo;
        n_cen   = r_cen;
        n_out_v = r_out_v && !i_m_tready;
        n_out_d = r_out_d;
        n_out_l = r_out_l;
        ps_raddr = r_lo;
        range_w = {1'b0, r_hi} - {1'b0, r_lo} + 1'b1;
        mid_w   = ({1'b0, r_lo} + {1'b0, r_hi}) >> 1;
        tot64   = 64'(r_total);
        prod0   = w * r_m;
        prod1   = w * range_w;
        o_s_tready = (r_state == ST_IDLE);

        if (r_p3_v) begin
            n_run = run_next;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_s_tuser == KIND_LOAD) begin
                        n_lp = r_lp + 1'b1;
                    end else begin
                        n_lp    = '0;
                        n_m     = (r_np == '0) ? NPW'(1)
                                : (r_np > NPW'(MAX_POINTS)) ? NPW'(MAX_POINTS) : r_np;
                        n_k     = (r_nc == '0) ? NCW'(1)
                                : (r_nc > NCW'(MAX_CENTERS)) ? NCW'(MAX_CENTERS) : r_nc;
                        n_dims  = (r_nd == '0) ? 3'd1 : (r_nd > 3'(DIMS)) ? 3'(DIMS) : r_nd;
                        n_c     = '0;
                        n_state = ST_DRAW0;
                    end
                end
            end
            ST_DRAW0: begin
                n_rand  = w;
                n_idx   = prod0[AW+31:32];
                n_state = ST_FETCH;
            end
            ST_FETCH: n_state = ST_FWAIT;
            ST_FWAIT: begin
                for (int d = 0; d < DIMS; d++) begin
                    n_cen[d] = (d < int'(r_dims)) ? r_pt_q[d*COORD_BITS +: COORD_BITS] : '0;
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_v || i_m_tready) begin
                    n_out_v = 1'b1;
                    n_out_d = OUT_BITS'({r_cen, r_idx, r_c});
                    n_out_l = ({1'b0, r_c} == r_k - 1'b1);
                    if ({1'b0, r_c} == r_k - 1'b1) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_first = (r_c == '0);
                        n_c     = r_c + 1'b1;
                        n_j     = '0;
                        n_run   = '0;
                        n_state = ST_PASS;
                    end
                end
            end
            ST_PASS: begin
                n_j = r_j + 1'b1;
                if ({1'b0, r_j} == r_m - 1'b1) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_p1_v && !r_p2_v && !r_p3_v) begin
                    n_total = r_run;
                    n_state = ST_KEY1;
                end
            end
            ST_KEY1: begin
                n_rand  = w;
                n_ph    = tot64[63:32] * w;
                n_pl    = tot64[31:0] * w;
                n_state = ST_KEY2;
            end
            ST_KEY2: begin
                n_key   = PSW'(r_ph + {32'd0, r_pl[63:32]});
                n_lo    = '0;
                n_hi    = AW'(r_m - 1'b1);
                n_state = ST_S_LO;
            end
            ST_S_LO: begin
                ps_raddr = r_lo;
                if (r_lo == r_hi) begin
                    n_idx   = r_lo;
                    n_state = ST_FETCH;
                end else begin
                    n_state = ST_S_HI;
                end
            end
            ST_S_HI: begin
                ps_raddr = r_hi;
                n_vlo    = r_ps_q;
                n_state  = ST_S_MID;
            end
            ST_S_MID: begin
                // Both ends at zero: every point in range is at distance zero.
                if (r_vlo == '0 && r_ps_q == '0) begin
                    n_rand  = w;
                    n_idx   = r_lo + prod1[AW+31:32];
                    n_state = ST_FETCH;
                end else begin
                    ps_raddr = mid_w[AW-1:0];
                    n_mid    = mid_w[AW-1:0];
                    n_state  = ST_S_CMP;
                end
            end
            ST_S_CMP: begin
                if (r_ps_q <= r_key) begin
                    n_lo = r_mid + 1'b1;
                end else begin
                    n_hi = r_mid;
                end
                n_state = ST_S_LO;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_d;
    assign o_m_tlast  = r_out_l;

`ifndef SYNTHESIS
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_p1_v && !r_p2_v && !r_p3_v))
        else $error("distance pipeline busy while idle");
    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_S_LO) |-> (r_lo <= r_hi))
        else $error("search bounds crossed");
    a_drain_to_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_KEY1) |-> (r_total == r_run))
        else $error("total differs from running sum");
`endif
endmodule
